### design/i2cm_pkg.sv
// ----------------------------------------------------------------------------
// I2C bit-level master package
// Shared request codes, sequencer phases, reset values and the queued item.
// ----------------------------------------------------------------------------
package i2cm_pkg;

    localparam int QUEUE_DEPTH_DEF = 2;
    localparam int CFG_IDX_W       = 1;

    localparam logic [2:0] REQ_START = 3'd0;
    localparam logic [2:0] REQ_STOP  = 3'd1;
    localparam logic [2:0] REQ_WRITE = 3'd2;
    localparam logic [2:0] REQ_READ  = 3'd3;
    localparam logic [2:0] REQ_WACK  = 3'd4;
    localparam logic [2:0] REQ_TICK  = 3'd5;

    localparam logic [CFG_IDX_W-1:0] CFG_TPU = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TMO = 1'd1;

    localparam logic [7:0] TPU_RST = 8'd5;
    localparam logic [7:0] TMO_RST = 8'd250;

    localparam logic [3:0] PH_IDLE = 4'd0;
    localparam logic [3:0] PH_ST1  = 4'd1;
    localparam logic [3:0] PH_ST2  = 4'd2;
    localparam logic [3:0] PH_SP1  = 4'd3;
    localparam logic [3:0] PH_SP2  = 4'd4;
    localparam logic [3:0] PH_WA1  = 4'd5;
    localparam logic [3:0] PH_WA2  = 4'd6;
    localparam logic [3:0] PH_WA3  = 4'd7;
    localparam logic [3:0] PH_WB1  = 4'd8;
    localparam logic [3:0] PH_WB2  = 4'd9;
    localparam logic [3:0] PH_WB3  = 4'd10;
    localparam logic [3:0] PH_RB1  = 4'd11;
    localparam logic [3:0] PH_RB2  = 4'd12;
    localparam logic [3:0] PH_RA1  = 4'd13;
    localparam logic [3:0] PH_RA2  = 4'd14;

    typedef struct packed {
        logic       is_tick;
        logic       is_cmd;
        logic [2:0] req_type;
        logic [7:0] tx_byte;
        logic       send_ack;
        logic       sda_in;
    } t_item;

endpackage

### design/i2cm_front.sv
// ----------------------------------------------------------------------------
// I2C master front end
// Accepts items, classifies them as tick, command or no-op, and queues them.
// ----------------------------------------------------------------------------
module i2cm_front #(
    parameter int QUEUE_DEPTH = i2cm_pkg::QUEUE_DEPTH_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  logic [2:0]       i_req_type,
    input  logic [7:0]       i_tx_byte,
    input  logic             i_send_ack,
    input  logic             i_sda_in,
    output logic             o_q_valid,
    output i2cm_pkg::t_item  o_q_item,
    input  logic             i_q_pop
);
    import i2cm_pkg::*;

    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PW-1:0] LAST = PW'(QUEUE_DEPTH - 1);
    localparam logic [CW-1:0] FULL = CW'(QUEUE_DEPTH);

    t_item          r_mem [QUEUE_DEPTH];
    logic [PW-1:0]  r_wr_ptr, r_rd_ptr;
    logic [CW-1:0]  r_count;
    logic           push, pop;
    t_item          item;

    always_comb begin
        item.is_tick  = (i_req_type == REQ_TICK);
        item.is_cmd   = (i_req_type <= REQ_WACK);
        item.req_type = i_req_type;
        item.tx_byte  = i_tx_byte;
        item.send_ack = i_send_ack;
        item.sda_in   = i_sda_in;
    end

    assign o_ready   = (r_count != FULL);
    assign o_q_valid = (r_count != '0);
    assign o_q_item  = r_mem[r_rd_ptr];
    assign push      = i_valid && o_ready;
    assign pop       = i_q_pop && o_q_valid;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= (r_wr_ptr == LAST) ? '0 : r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST) ? '0 : r_rd_ptr + 1'b1;
            end
            if (push && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (pop && !push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

### design/i2cm_back.sv
// ----------------------------------------------------------------------------
// I2C master back end
// Bus sequencer that runs one queued item per cycle into an output register while the output is not stalled.
// ----------------------------------------------------------------------------
module i2cm_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_q_valid,
    input  i2cm_pkg::t_item  i_q_item,
    output logic             o_q_pop,
    input  logic [7:0]       i_ticks_per_unit,
    input  logic [7:0]       i_ack_timeout,
    output logic             o_valid,
    input  logic             i_ready,
    output logic             o_scl_out,
    output logic             o_sda_out,
    output logic             o_busy_res,
    output logic             o_done_res,
    output logic [7:0]       o_rx_byte,
    output logic             o_ack_failed
);
    import i2cm_pkg::*;

    logic [3:0]  r_phase, n_phase;
    logic [3:0]  r_bit_count, n_bit_count;
    logic [7:0]  r_shift, n_shift;
    logic [11:0] r_delay, n_delay;
    logic [7:0]  r_timeout, n_timeout;
    logic        r_scl, n_scl;
    logic        r_sda, n_sda;
    logic        r_ack_choice, n_ack_choice;
    logic        r_fail, n_fail;
    logic [7:0]  r_rx, n_rx;
    logic        n_done;

    logic        r_out_valid;
    logic        r_out_scl, r_out_sda, r_out_busy, r_out_done, r_out_fail;
    logic [7:0]  r_out_rx;

    logic [11:0] dly1, dly2, dly4, dec;
    logic [7:0]  tpu;
    logic [3:0]  bc1;

    assign tpu  = (i_ticks_per_unit == 8'd0) ? 8'd1 : i_ticks_per_unit;
    assign dly1 = {4'd0, tpu};
    assign dly2 = {3'd0, tpu, 1'b0};
    assign dly4 = {2'd0, tpu, 2'b0};
    assign dec  = (r_delay != 12'd0) ? r_delay - 12'd1 : 12'd0;
    assign bc1  = r_bit_count + 4'd1;

    assign o_q_pop = i_q_valid && (!r_out_valid || i_ready);

    always_comb begin
        n_phase      = r_phase;
        n_bit_count  = r_bit_count;
        n_shift      = r_shift;
        n_delay      = r_delay;
        n_timeout    = r_timeout;
        n_scl        = r_scl;
        n_sda        = r_sda;
        n_ack_choice = r_ack_choice;
        n_fail       = r_fail;
        n_rx         = r_rx;
        n_done       = 1'b0;
        if (i_q_item.is_tick) begin
            if (r_phase == PH_WA3) begin
                if (!i_q_item.sda_in) begin
                    n_scl   = 1'b0;
                    n_phase = PH_IDLE;
                    n_done  = 1'b1;
                end else if (r_timeout >= i_ack_timeout) begin
                    n_fail  = 1'b1;
                    n_scl   = 1'b0;
                    n_sda   = 1'b0;
                    n_phase = PH_SP1;
                    n_delay = dly4;
                end else begin
                    n_timeout = r_timeout + 8'd1;
                end
            end else if (r_phase != PH_IDLE) begin
                n_delay = dec;
                if (dec == 12'd0) begin
                    unique case (r_phase)
                        PH_ST1: begin
                            n_sda = 1'b0; n_phase = PH_ST2; n_delay = dly4;
                        end
                        PH_ST2: begin
                            n_scl = 1'b0; n_phase = PH_IDLE; n_done = 1'b1;
                        end
                        PH_SP1: begin
                            n_scl = 1'b1; n_sda = 1'b1;
                            n_phase = PH_SP2; n_delay = dly4;
                        end
                        PH_SP2: begin
                            n_phase = PH_IDLE; n_done = 1'b1;
                        end
                        PH_WA1: begin
                            n_scl = 1'b1; n_phase = PH_WA2; n_delay = dly1;
                        end
                        PH_WA2: begin
                            n_timeout = 8'd0; n_phase = PH_WA3;
                        end
                        PH_WB1: begin
                            n_scl = 1'b1; n_phase = PH_WB2; n_delay = dly2;
                        end
                        PH_WB2: begin
                            n_scl = 1'b0; n_phase = PH_WB3; n_delay = dly2;
                        end
                        PH_WB3: begin
                            n_bit_count = bc1;
                            if (bc1 >= 4'd8) begin
                                n_phase = PH_IDLE; n_done = 1'b1;
                            end else begin
                                n_sda   = r_shift[7];
                                n_shift = {r_shift[6:0], 1'b0};
                                n_phase = PH_WB1;
                                n_delay = dly2;
                            end
                        end
                        PH_RB1: begin
                            n_scl   = 1'b1;
                            n_shift = {r_shift[6:0], i_q_item.sda_in};
                            n_phase = PH_RB2;
                            n_delay = dly2;
                        end
                        PH_RB2: begin
                            n_bit_count = bc1;
                            n_scl       = 1'b0;
                            n_delay     = dly2;
                            if (bc1 < 4'd8) begin
                                n_phase = PH_RB1;
                            end else begin
                                n_rx    = r_shift;
                                n_sda   = ~r_ack_choice;
                                n_phase = PH_RA1;
                            end
                        end
                        PH_RA1: begin
                            n_scl = 1'b1; n_phase = PH_RA2; n_delay = dly2;
                        end
                        PH_RA2: begin
                            n_scl = 1'b0; n_phase = PH_IDLE; n_done = 1'b1;
                        end
                        default: begin
                            n_phase = PH_IDLE;
                        end
                    endcase
                end
            end
        end else if (i_q_item.is_cmd && r_phase == PH_IDLE) begin
            unique case (i_q_item.req_type)
                REQ_START: begin
                    n_sda = 1'b1; n_scl = 1'b1; n_phase = PH_ST1; n_delay = dly4;
                end
                REQ_STOP: begin
                    n_scl = 1'b0; n_sda = 1'b0; n_phase = PH_SP1; n_delay = dly4;
                end
                REQ_WRITE: begin
                    n_scl       = 1'b0;
                    n_bit_count = 4'd0;
                    n_sda       = i_q_item.tx_byte[7];
                    n_shift     = {i_q_item.tx_byte[6:0], 1'b0};
                    n_phase     = PH_WB1;
                    n_delay     = dly2;
                end
                REQ_READ: begin
                    n_scl        = 1'b0;
                    n_sda        = 1'b1;
                    n_bit_count  = 4'd0;
                    n_shift      = 8'd0;
                    n_ack_choice = i_q_item.send_ack;
                    n_phase      = PH_RB1;
                    n_delay      = dly2;
                end
                default: begin
                    n_fail  = 1'b0;
                    n_sda   = 1'b1;
                    n_phase = PH_WA1;
                    n_delay = dly1;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_IDLE;
            r_bit_count  <= 4'd0;
            r_shift      <= 8'd0;
            r_delay      <= 12'd0;
            r_timeout    <= 8'd0;
            r_scl        <= 1'b1;
            r_sda        <= 1'b1;
            r_ack_choice <= 1'b0;
            r_fail       <= 1'b0;
            r_rx         <= 8'd0;
            r_out_valid  <= 1'b0;
        end else begin
            if (o_q_pop) begin
                r_phase      <= n_phase;
                r_bit_count  <= n_bit_count;
                r_shift      <= n_shift;
                r_delay      <= n_delay;
                r_timeout    <= n_timeout;
                r_scl        <= n_scl;
                r_sda        <= n_sda;
                r_ack_choice <= n_ack_choice;
                r_fail       <= n_fail;
                r_rx         <= n_rx;
                r_out_valid  <= 1'b1;
            end else if (i_ready) begin
                r_out_valid  <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_out_scl  <= n_scl;
            r_out_sda  <= n_sda;
            r_out_busy <= (n_phase != PH_IDLE);
            r_out_done <= n_done;
            r_out_rx   <= n_rx;
            r_out_fail <= n_fail;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_scl_out    = r_out_scl;
    assign o_sda_out    = r_out_sda;
    assign o_busy_res   = r_out_busy;
    assign o_done_res   = r_out_done;
    assign o_rx_byte    = r_out_rx;
    assign o_ack_failed = r_out_fail;

endmodule

### design/i2c_bit_level_master.sv
// ----------------------------------------------------------------------------
// I2C bit-level master
// Open-drain SCL/SDA sequencer driven by command and tick transfers.
// ----------------------------------------------------------------------------
// Takes one transfer per clock while the result output is not stalled and
// returns one result per transfer, in order. A transfer is written into a
// QUEUE_DEPTH-entry input queue and leaves it through the bus sequencer,
// which loads the output register as it pops the entry; the result is then
// held on the output ports until it is taken.
// Bus timing counts tick transfers: a delay of n units is n * ticks_per_unit
// ticks (a zero setting acts as one). Write registers only while idle;
// o_cfg_ready is always high.
// ----------------------------------------------------------------------------
module i2c_bit_level_master #(
    parameter int QUEUE_DEPTH = i2cm_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic [2:0]                     i_req_type,
    input  logic [7:0]                     i_tx_byte,
    input  logic                           i_send_ack,
    input  logic                           i_sda_in,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic                           o_scl_out,
    output logic                           o_sda_out,
    output logic                           o_busy_res,
    output logic                           o_done_res,
    output logic [7:0]                     o_rx_byte,
    output logic                           o_ack_failed,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [i2cm_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [7:0]                     i_cfg_data
);
    import i2cm_pkg::*;

    logic [7:0] r_ticks_per_unit;
    logic [7:0] r_ack_timeout;
    logic       q_valid;
    logic       q_pop;
    t_item      q_item;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ticks_per_unit <= TPU_RST;
            r_ack_timeout    <= TMO_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_TPU: r_ticks_per_unit <= i_cfg_data;
                CFG_TMO: r_ack_timeout    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    i2cm_front #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_in_valid),
        .o_ready    (o_in_ready),
        .i_req_type (i_req_type),
        .i_tx_byte  (i_tx_byte),
        .i_send_ack (i_send_ack),
        .i_sda_in   (i_sda_in),
        .o_q_valid  (q_valid),
        .o_q_item   (q_item),
        .i_q_pop    (q_pop)
    );

    i2cm_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_q_valid        (q_valid),
        .i_q_item         (q_item),
        .o_q_pop          (q_pop),
        .i_ticks_per_unit (r_ticks_per_unit),
        .i_ack_timeout    (r_ack_timeout),
        .o_valid          (o_out_valid),
        .i_ready          (i_out_ready),
        .o_scl_out        (o_scl_out),
        .o_sda_out        (o_sda_out),
        .o_busy_res       (o_busy_res),
        .o_done_res       (o_done_res),
        .o_rx_byte        (o_rx_byte),
        .o_ack_failed     (o_ack_failed)
    );

endmodule

### design/i2cm_checker.sv
// ----------------------------------------------------------------------------
// I2C master port checker
// Port-level checks on the result channel, attached to the top level.
// ----------------------------------------------------------------------------
module i2cm_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_out_valid,
    input logic       i_out_ready,
    input logic       o_scl_out,
    input logic       o_sda_out,
    input logic       o_busy_res,
    input logic       o_done_res,
    input logic [7:0] o_rx_byte,
    input logic       o_ack_failed
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_rx_byte)
        && $stable(o_scl_out) && $stable(o_sda_out) && $stable(o_done_res))
        else $error("result changed while stalled");

    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_done_res |-> !o_busy_res)
        else $error("done reported while still busy");

    a_known: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !$isunknown({o_scl_out, o_sda_out, o_busy_res, o_done_res,
                                     o_rx_byte, o_ack_failed}))
        else $error("unknown value in a valid result");

endmodule

bind i2c_bit_level_master i2cm_checker u_i2cm_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_out_valid  (o_out_valid),
    .i_out_ready  (i_out_ready),
    .o_scl_out    (o_scl_out),
    .o_sda_out    (o_sda_out),
    .o_busy_res   (o_busy_res),
    .o_done_res   (o_done_res),
    .o_rx_byte    (o_rx_byte),
    .o_ack_failed (o_ack_failed)
);

### test/i2c_bit_level_master_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C bit-level master testbench
// Drives command and tick transfers into the master and checks every pin and
// status snapshot against a cycle-free bus sequencer model kept in the bench.
// A directed part covers each command, idle ticks, reserved requests, commands
// while busy, zero and full-scale timing settings and ACK timeouts; random
// phases then run well-formed command/tick sequences mixed with broken ones
// and noise, under several sender-idle and receiver-stall mixes.
// ----------------------------------------------------------------------------
module i2c_bit_level_master_tb;
    import i2cm_pkg::*;

    localparam logic [2:0] REQ_RSVD6 = 3'd6;
    localparam logic [2:0] REQ_RSVD7 = 3'd7;
    localparam int         NO_LIMIT  = 1 << 30;

    typedef struct {
        logic       scl;
        logic       sda;
        logic       busy;
        logic       done;
        logic [7:0] rx;
        logic       fail;
    } t_snap;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 in_valid  = 1'b0;
    logic [2:0]           req_type  = REQ_TICK;
    logic [7:0]           tx_byte   = 8'h00;
    logic                 send_ack  = 1'b0;
    logic                 sda_in    = 1'b1;
    logic                 out_ready = 1'b1;
    logic                 cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = CFG_TPU;
    logic [7:0]           cfg_data  = 8'h00;

    logic                 o_in_ready;
    logic                 o_out_valid;
    logic                 o_scl_out;
    logic                 o_sda_out;
    logic                 o_busy_res;
    logic                 o_done_res;
    logic [7:0]           o_rx_byte;
    logic                 o_ack_failed;
    logic                 o_cfg_ready;

    // bus sequencer model state
    logic [3:0]  m_phase   = PH_IDLE;
    logic [3:0]  m_bits    = 4'd0;
    logic [7:0]  m_shift   = 8'h00;
    logic [11:0] m_delay   = 12'd0;
    logic [7:0]  m_polls   = 8'd0;
    logic        m_scl     = 1'b1;
    logic        m_sda     = 1'b1;
    logic        m_ack_sel = 1'b0;
    logic        m_fail    = 1'b0;
    logic [7:0]  m_rx      = 8'h00;
    logic [7:0]  cfg_tpu   = TPU_RST;
    logic [7:0]  cfg_tmo   = TMO_RST;

    t_snap pending_snaps[$];
    int    send_idle_pct = 0;
    int    stall_pct     = 0;
    int    item_count    = 0;
    int    snap_count    = 0;
    int    mismatches    = 0;

    i2c_bit_level_master uut (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .o_in_ready   (o_in_ready),
        .i_req_type   (req_type),
        .i_tx_byte    (tx_byte),
        .i_send_ack   (send_ack),
        .i_sda_in     (sda_in),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (out_ready),
        .o_scl_out    (o_scl_out),
        .o_sda_out    (o_sda_out),
        .o_busy_res   (o_busy_res),
        .o_done_res   (o_done_res),
        .o_rx_byte    (o_rx_byte),
        .o_ack_failed (o_ack_failed),
        .i_cfg_valid  (cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data)
    );

    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    always @(posedge clk) begin
        out_ready <= ($urandom_range(99) >= stall_pct);
    end

    task automatic load_delay(input logic [3:0] ph, input int units);
        int tpu_eff;
        int prod;
        tpu_eff = (cfg_tpu == 8'd0) ? 1 : int'(cfg_tpu);
        prod    = units * tpu_eff;
        m_phase = ph;
        m_delay = prod[11:0];
    endtask

    task automatic step_phase(input logic sda, output logic done);
        done = 1'b0;
        case (m_phase)
            PH_ST1: begin
                m_sda = 1'b0;
                load_delay(PH_ST2, 4);
            end
            PH_ST2: begin
                m_scl   = 1'b0;
                m_phase = PH_IDLE;
                done    = 1'b1;
            end
            PH_SP1: begin
                m_scl = 1'b1;
                m_sda = 1'b1;
                load_delay(PH_SP2, 4);
            end
            PH_SP2: begin
                m_phase = PH_IDLE;
                done    = 1'b1;
            end
            PH_WA1: begin
                m_scl = 1'b1;
                load_delay(PH_WA2, 1);
            end
            PH_WA2: begin
                m_polls = 8'd0;
                m_phase = PH_WA3;
            end
            PH_WB1: begin
                m_scl = 1'b1;
                load_delay(PH_WB2, 2);
            end
            PH_WB2: begin
                m_scl = 1'b0;
                load_delay(PH_WB3, 2);
            end
            PH_WB3: begin
                m_bits = m_bits + 4'd1;
                if (m_bits >= 4'd8) begin
                    m_phase = PH_IDLE;
                    done    = 1'b1;
                end else begin
                    m_sda   = m_shift[7];
                    m_shift = {m_shift[6:0], 1'b0};
                    load_delay(PH_WB1, 2);
                end
            end
            PH_RB1: begin
                m_scl   = 1'b1;
                m_shift = {m_shift[6:0], sda};
                load_delay(PH_RB2, 2);
            end
            PH_RB2: begin
                m_bits = m_bits + 4'd1;
                m_scl  = 1'b0;
                if (m_bits < 4'd8) begin
                    load_delay(PH_RB1, 2);
                end else begin
                    m_rx  = m_shift;
                    m_sda = !m_ack_sel;
                    load_delay(PH_RA1, 2);
                end
            end
            PH_RA1: begin
                m_scl = 1'b1;
                load_delay(PH_RA2, 2);
            end
            PH_RA2: begin
                m_scl   = 1'b0;
                m_phase = PH_IDLE;
                done    = 1'b1;
            end
            default: begin
                m_phase = PH_IDLE;
            end
        endcase
    endtask

    task automatic predict_snapshot(input logic [2:0] req, input logic [7:0] tx,
                                    input logic sack, input logic sda);
        t_snap s;
        logic  done;
        done = 1'b0;
        if (req == REQ_TICK) begin
            if (m_phase == PH_WA3) begin
                if (!sda) begin
                    m_scl   = 1'b0;
                    m_phase = PH_IDLE;
                    done    = 1'b1;
                end else if (m_polls >= cfg_tmo) begin
                    m_fail = 1'b1;
                    m_scl  = 1'b0;
                    m_sda  = 1'b0;
                    load_delay(PH_SP1, 4);
                end else begin
                    m_polls = m_polls + 8'd1;
                end
            end else if (m_phase != PH_IDLE) begin
                if (m_delay != 12'd0) m_delay = m_delay - 12'd1;
                if (m_delay == 12'd0) step_phase(sda, done);
            end
        end else if (req <= REQ_WACK && m_phase == PH_IDLE) begin
            case (req)
                REQ_START: begin
                    m_sda = 1'b1;
                    m_scl = 1'b1;
                    load_delay(PH_ST1, 4);
                end
                REQ_STOP: begin
                    m_scl = 1'b0;
                    m_sda = 1'b0;
                    load_delay(PH_SP1, 4);
                end
                REQ_WRITE: begin
                    m_scl   = 1'b0;
                    m_bits  = 4'd0;
                    m_sda   = tx[7];
                    m_shift = {tx[6:0], 1'b0};
                    load_delay(PH_WB1, 2);
                end
                REQ_READ: begin
                    m_scl     = 1'b0;
                    m_sda     = 1'b1;
                    m_bits    = 4'd0;
                    m_shift   = 8'h00;
                    m_ack_sel = sack;
                    load_delay(PH_RB1, 2);
                end
                default: begin
                    m_fail = 1'b0;
                    m_sda  = 1'b1;
                    load_delay(PH_WA1, 1);
                end
            endcase
        end
        s.scl  = m_scl;
        s.sda  = m_sda;
        s.busy = (m_phase != PH_IDLE);
        s.done = done;
        s.rx   = m_rx;
        s.fail = m_fail;
        pending_snaps.push_back(s);
    endtask

    task automatic send_item(input logic [2:0] req, input logic [7:0] tx,
                             input logic sack, input logic sda);
        int gap;
        gap = 0;
        while (gap < 8 && $urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
            gap++;
        end
        in_valid <= 1'b1;
        req_type <= req;
        tx_byte  <= tx;
        send_ack <= sack;
        sda_in   <= sda;
        do @(negedge clk); while (!o_in_ready);
        @(posedge clk);
        predict_snapshot(req, tx, sack, sda);
        item_count++;
    endtask

    task automatic finish_bus();
        while (m_phase != PH_IDLE) begin
            send_item(REQ_TICK, 8'($urandom), 1'($urandom_range(1)), 1'($urandom_range(1)));
        end
    endtask

    task automatic run_command(input logic [2:0] req, input logic [7:0] tx, input logic sack,
                               input logic [7:0] rd_data, input int ack_after,
                               input int max_ticks);
        int   polls;
        int   ticks;
        logic sda;
        polls = 0;
        ticks = 0;
        send_item(req, tx, sack, 1'($urandom_range(1)));
        while (m_phase != PH_IDLE && ticks < max_ticks) begin
            if (m_phase == PH_RB1) begin
                sda = rd_data[3'd7 - m_bits[2:0]];
            end else if (m_phase == PH_WA3) begin
                sda = (polls < ack_after);
                polls++;
            end else begin
                sda = 1'($urandom_range(1));
            end
            send_item(REQ_TICK, 8'($urandom), 1'($urandom_range(1)), sda);
            ticks++;
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] data);
        finish_bus();
        in_valid <= 1'b0;
        while (pending_snaps.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(negedge clk); while (!o_cfg_ready);
        @(posedge clk);
        if (idx == CFG_TPU) cfg_tpu = data;
        else cfg_tmo = data;
        cfg_valid <= 1'b0;
    endtask

    always @(negedge clk) begin : result_check
        t_snap want;
        if (rst_n && o_out_valid && out_ready) begin
            if (pending_snaps.size() == 0) begin
                $error("result transfer with no expected snapshot");
                mismatches++;
            end else begin
                want = pending_snaps.pop_front();
                if (o_scl_out !== want.scl) begin
                    $error("scl_out: expected %0d, got %0d", want.scl, o_scl_out);
                    mismatches++;
                end
                if (o_sda_out !== want.sda) begin
                    $error("sda_out: expected %0d, got %0d", want.sda, o_sda_out);
                    mismatches++;
                end
                if (o_busy_res !== want.busy) begin
                    $error("busy_res: expected %0d, got %0d", want.busy, o_busy_res);
                    mismatches++;
                end
                if (o_done_res !== want.done) begin
                    $error("done_res: expected %0d, got %0d", want.done, o_done_res);
                    mismatches++;
                end
                if (o_rx_byte !== want.rx) begin
                    $error("rx_byte: expected 0x%02h, got 0x%02h", want.rx, o_rx_byte);
                    mismatches++;
                end
                if (o_ack_failed !== want.fail) begin
                    $error("ack_failed: expected %0d, got %0d", want.fail, o_ack_failed);
                    mismatches++;
                end
                snap_count++;
            end
        end
    end

    task automatic test_idle_noise();
        send_item(REQ_TICK, 8'h00, 1'b0, 1'b0);
        send_item(REQ_TICK, 8'hFF, 1'b1, 1'b1);
        send_item(REQ_RSVD6, 8'h00, 1'b0, 1'b0);
        send_item(REQ_RSVD7, 8'hFF, 1'b1, 1'b1);
    endtask

    task automatic test_basic_ops();
        run_command(REQ_START, 8'h00, 1'b0, 8'h00, 0, NO_LIMIT);
        write_reg(CFG_TPU, 8'd1);
        run_command(REQ_WRITE, 8'hFF, 1'b0, 8'h00, 0, NO_LIMIT);
        run_command(REQ_WRITE, 8'h00, 1'b1, 8'h00, 0, NO_LIMIT);
        run_command(REQ_WACK, 8'h00, 1'b0, 8'h00, 0, NO_LIMIT);
        run_command(REQ_READ, 8'h00, 1'b1, 8'hFF, 0, NO_LIMIT);
        run_command(REQ_READ, 8'hFF, 1'b0, 8'h00, 0, NO_LIMIT);
        run_command(REQ_READ, 8'h00, 1'b1, 8'hA5, 0, NO_LIMIT);
        run_command(REQ_WACK, 8'h00, 1'b0, 8'h00, 3, NO_LIMIT);
        run_command(REQ_STOP, 8'h00, 1'b0, 8'h00, 0, NO_LIMIT);
    endtask

    task automatic test_busy_ignore();
        run_command(REQ_WRITE, 8'h5A, 1'b0, 8'h00, 0, 7);
        send_item(REQ_STOP, 8'h00, 1'b0, 1'b1);
        send_item(REQ_RSVD6, 8'hFF, 1'b1, 1'b1);
        send_item(REQ_RSVD7, 8'h00, 1'b0, 1'b0);
        send_item(REQ_READ, 8'hFF, 1'b1, 1'b0);
        send_item(REQ_WACK, 8'h00, 1'b0, 1'b1);
        finish_bus();
    endtask

    task automatic test_timing_extremes();
        write_reg(CFG_TPU, 8'd0);
        write_reg(CFG_TMO, 8'd0);
        run_command(REQ_START, 8'h00, 1'b0, 8'h00, 0, NO_LIMIT);
        run_command(REQ_WACK, 8'h00, 1'b0, 8'h00, 5, NO_LIMIT);
        run_command(REQ_STOP, 8'h00, 1'b0, 8'h00, 0, NO_LIMIT);
        write_reg(CFG_TPU, 8'd255);
        write_reg(CFG_TMO, 8'd255);
        run_command(REQ_WACK, 8'h00, 1'b0, 8'h00, 0, NO_LIMIT);
        write_reg(CFG_TPU, 8'd1);
        write_reg(CFG_TMO, 8'd1);
        run_command(REQ_WRITE, 8'h3C, 1'b0, 8'h00, 0, NO_LIMIT);
        run_command(REQ_WACK, 8'h00, 1'b0, 8'h00, 1, NO_LIMIT);
        run_command(REQ_READ, 8'h00, 1'b0, 8'hC3, 0, NO_LIMIT);
    endtask

    task automatic test_random_traffic(input int idle, input int stall, input int n_items,
                                       input int tpu, input int tmo);
        int         first;
        int         r;
        logic [2:0] cmd;
        write_reg(CFG_TPU, tpu[7:0]);
        write_reg(CFG_TMO, tmo[7:0]);
        send_idle_pct = idle;
        stall_pct     = stall;
        first         = item_count;
        while (item_count - first < n_items) begin
            r   = $urandom_range(99);
            cmd = 3'($urandom_range(REQ_WACK, REQ_START));
            if (r < 80) begin
                run_command(cmd, 8'($urandom), 1'($urandom_range(1)), 8'($urandom),
                            $urandom_range(tmo + 3, 0), NO_LIMIT);
            end else if (r < 92) begin
                // cut a sequence short, send one random item at the block, which may still be busy, then drain
                run_command(cmd, 8'($urandom), 1'($urandom_range(1)), 8'($urandom),
                            $urandom_range(tmo + 3, 0), $urandom_range(12, 0));
                send_item(3'($urandom_range(7)), 8'($urandom), 1'($urandom_range(1)),
                          1'($urandom_range(1)));
                finish_bus();
            end else begin
                send_item(3'($urandom_range(7)), 8'($urandom), 1'($urandom_range(1)),
                          1'($urandom_range(1)));
            end
        end
    endtask

    initial begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_idle_noise();
        test_basic_ops();
        test_busy_ignore();
        test_timing_extremes();

        test_random_traffic(0, 0, 50, 1, $urandom_range(8, 1));
        test_random_traffic(54, 0, 50, $urandom_range(2, 1), $urandom_range(30, 1));
        test_random_traffic(0, 54, 50, 1, $urandom_range(20, 4));
        test_random_traffic(16, 16, 50, $urandom_range(2, 1), $urandom_range(16, 1));

        in_valid <= 1'b0;
        while (pending_snaps.size() != 0) @(posedge clk);
        repeat (8) @(posedge clk);

        $display("Ran %0d transfers in and checked %0d snapshots out,", item_count, snap_count);
        $display("covering every command, timing settings 0..255 and four idle/stall mixes.");
        if (mismatches == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    initial begin
        #20_000_000;
        $display("timeout with %0d snapshots outstanding", pending_snaps.size());
        $display("Some tests failed");
        $finish;
    end

endmodule

### files.f
design/i2cm_pkg.sv
design/i2cm_front.sv
design/i2cm_back.sv
design/i2c_bit_level_master.sv
design/i2cm_checker.sv
test/i2c_bit_level_master_tb.sv
